// File: rtl/blr_pkg.sv
// Shared constants, codes and helpers of the line rasterizer.
package blr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [1:0] KIND_START    = 2'd0;
    localparam logic [1:0] KIND_INTERIOR = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;

    // decision term and its increments: coordinate width plus three
    function automatic int decision_bits(input int coord_bits);
        return coord_bits + 3;
    endfunction

    // queue entry: cmd, four coordinates, span, three decision words, three flags
    function automatic int entry_bits(input int coord_bits);
        return 1 + 4 * coord_bits + (coord_bits + 1) + 3 * decision_bits(coord_bits) + 3;
    endfunction

endpackage

// File: rtl/blr_if.sv
// Channel interfaces: line commands in, pixels out.
interface blr_cmd_if #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;

    modport source (output valid, cmd, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, cmd, x_start, y_start, x_end, y_end, output ready);
endinterface

interface blr_pixel_if #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [1:0]                   pixel_kind;
    logic                         valid_res;
    logic                         last;

    modport source (output valid, pixel_x, pixel_y, pixel_kind, valid_res, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_kind, valid_res, last, output ready);
endinterface

// File: rtl/bresenham_line_rasterizer.sv
// Bresenham line rasterizer, all octants. A load transaction (cmd 0) takes start and end
// points and gives no pixel; each step transaction (cmd 1) gives exactly one pixel: the start,
// then the interior points from the start up to but not including the end along the major
// axis, then the end marked last; a step with no line in progress gives a pixel with
// valid_res clear. The front end works out the spans and decision term in the cycle of acceptance
// and writes a two-entry queue, and the back end advances the decision term with one add per
// interior step and puts each pixel in an output register, so a new command is taken every
// cycle while the pixel side does not stall; a pixel passes through the queue and then the
// output register once its step command is accepted, later while the pixel side stalls.
module bresenham_line_rasterizer #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    blr_cmd_if.sink     item,
    blr_pixel_if.source pixel
);
    import blr_pkg::*;

    localparam int EntryBits = entry_bits(COORD_BITS);

    logic                 push_valid;
    logic                 push_ready;
    logic [EntryBits-1:0] push_data;
    logic                 pop_valid;
    logic                 pop_ready;
    logic [EntryBits-1:0] pop_data;

    blr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    blr_queue #(
        .WIDTH (EntryBits),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    blr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .pixel     (pixel)
    );

endmodule

// File: rtl/blr_front.sv
// Front end: accepts commands, works out spans, octant and initial decision term.
module blr_front #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
    blr_cmd_if.sink                                       item,
    output logic                                          push_valid,
    input  logic                                          push_ready,
    output logic [blr_pkg::entry_bits(COORD_BITS)-1:0]    push_data
);
    import blr_pkg::*;

    localparam int SpanBits = COORD_BITS + 1;
    localparam int DecBits  = decision_bits(COORD_BITS);

    logic [SpanBits-1:0] dx;
    logic [SpanBits-1:0] dy;
    logic [SpanBits-1:0] ax;
    logic [SpanBits-1:0] ay;
    logic                dir_x_neg;
    logic                dir_y_neg;
    logic                y_major;
    logic [SpanBits-1:0] span_major;
    logic [SpanBits-1:0] span_minor;
    logic [DecBits-1:0]  major_ext;
    logic [DecBits-1:0]  minor_ext;
    logic [DecBits-1:0]  inc_axial;
    logic [DecBits-1:0]  inc_diag;
    logic [DecBits-1:0]  decision0;

    assign dx = {item.x_end[COORD_BITS-1], item.x_end}
              - {item.x_start[COORD_BITS-1], item.x_start};
    assign dy = {item.y_end[COORD_BITS-1], item.y_end}
              - {item.y_start[COORD_BITS-1], item.y_start};

    assign ax = dx[SpanBits-1] ? (~dx + SpanBits'(1)) : dx;
    assign ay = dy[SpanBits-1] ? (~dy + SpanBits'(1)) : dy;

    // zero delta counts as negative
    assign dir_x_neg = dx[SpanBits-1] || (dx == '0);
    assign dir_y_neg = dy[SpanBits-1] || (dy == '0);

    assign y_major    = ay > ax;
    assign span_major = y_major ? ay : ax;
    assign span_minor = y_major ? ax : ay;

    assign major_ext = DecBits'(span_major);
    assign minor_ext = DecBits'(span_minor);
    assign inc_axial = minor_ext << 1;
    assign inc_diag  = (minor_ext - major_ext) << 1;
    assign decision0 = (minor_ext << 1) - major_ext;

    assign push_valid = item.valid;
    assign item.ready = push_ready;
    assign push_data  = {item.cmd, item.x_start, item.y_start, item.x_end, item.y_end,
                         span_major, inc_axial, inc_diag, decision0,
                         dir_x_neg, dir_y_neg, y_major};

endmodule

// File: rtl/blr_queue.sv
// Short register FIFO between the front and back ends.
module blr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = blr_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import blr_pkg::*;

    localparam int PtrBits   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountBits = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]     mem_reg [DEPTH];
    logic [PtrBits-1:0]   wr_ptr_reg;
    logic [PtrBits-1:0]   rd_ptr_reg;
    logic [CountBits-1:0] count_reg;
    logic                 push;
    logic                 pop;

    assign push_ready = count_reg != CountBits'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrBits'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrBits'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CountBits'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CountBits'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/blr_back.sv
// Back end: line state, Bresenham stepping and the pixel output register.
module blr_back #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       pop_valid,
    output logic                                       pop_ready,
    input  logic [blr_pkg::entry_bits(COORD_BITS)-1:0] pop_data,
    blr_pixel_if.source                                pixel
);
    import blr_pkg::*;

    localparam int SpanBits = COORD_BITS + 1;
    localparam int DecBits  = decision_bits(COORD_BITS);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_INTERIOR,
        PH_END
    } phase_t;

    // unpacked queue entry
    logic                  e_cmd;
    logic [COORD_BITS-1:0] e_x_start;
    logic [COORD_BITS-1:0] e_y_start;
    logic [COORD_BITS-1:0] e_x_end;
    logic [COORD_BITS-1:0] e_y_end;
    logic [SpanBits-1:0]   e_span;
    logic [DecBits-1:0]    e_inc_axial;
    logic [DecBits-1:0]    e_inc_diag;
    logic [DecBits-1:0]    e_decision;
    logic                  e_dir_x_neg;
    logic                  e_dir_y_neg;
    logic                  e_y_major;

    phase_t                phase_reg, phase_next;
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0] end_x_reg, end_x_next;
    logic [COORD_BITS-1:0] end_y_reg, end_y_next;
    logic [SpanBits-1:0]   remaining_reg, remaining_next;
    logic [DecBits-1:0]    inc_axial_reg, inc_axial_next;
    logic [DecBits-1:0]    inc_diag_reg, inc_diag_next;
    logic [DecBits-1:0]    decision_reg, decision_next;
    logic                  dir_x_neg_reg, dir_x_neg_next;
    logic                  dir_y_neg_reg, dir_y_neg_next;
    logic                  y_major_reg, y_major_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] out_x_reg, out_x_next;
    logic [COORD_BITS-1:0] out_y_reg, out_y_next;
    logic [1:0]            out_kind_reg, out_kind_next;
    logic                  out_res_reg, out_res_next;
    logic                  out_last_reg, out_last_next;

    logic                  out_free;
    logic                  fire;
    logic                  minor_step;
    logic                  move_x;
    logic                  move_y;
    logic [COORD_BITS-1:0] step_x;
    logic [COORD_BITS-1:0] step_y;

    assign {e_cmd, e_x_start, e_y_start, e_x_end, e_y_end, e_span, e_inc_axial, e_inc_diag,
            e_decision, e_dir_x_neg, e_dir_y_neg, e_y_major} = pop_data;

    // loads never wait on the output side
    assign out_free  = !out_valid_reg || pixel.ready;
    assign pop_ready = (e_cmd == CMD_LOAD) || out_free;
    assign fire      = pop_valid && pop_ready;

    assign minor_step = !decision_reg[DecBits-1];
    assign move_x     = y_major_reg ? minor_step : 1'b1;
    assign move_y     = y_major_reg ? 1'b1 : minor_step;
    assign step_x     = dir_x_neg_reg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
    assign step_y     = dir_y_neg_reg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);

    always_comb
    begin
        phase_next     = phase_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        end_x_next     = end_x_reg;
        end_y_next     = end_y_reg;
        remaining_next = remaining_reg;
        inc_axial_next = inc_axial_reg;
        inc_diag_next  = inc_diag_reg;
        decision_next  = decision_reg;
        dir_x_neg_next = dir_x_neg_reg;
        dir_y_neg_next = dir_y_neg_reg;
        y_major_next   = y_major_reg;
        out_valid_next = out_valid_reg && !pixel.ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_kind_next  = out_kind_reg;
        out_res_next   = out_res_reg;
        out_last_next  = out_last_reg;

        if (fire)
        begin
            if (e_cmd == CMD_LOAD)
            begin
                cur_x_next     = e_x_start;
                cur_y_next     = e_y_start;
                end_x_next     = e_x_end;
                end_y_next     = e_y_end;
                remaining_next = e_span;
                inc_axial_next = e_inc_axial;
                inc_diag_next  = e_inc_diag;
                decision_next  = e_decision;
                dir_x_neg_next = e_dir_x_neg;
                dir_y_neg_next = e_dir_y_neg;
                y_major_next   = e_y_major;
                phase_next     = PH_START;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_x_next     = cur_x_reg;
                out_y_next     = cur_y_reg;
                out_kind_next  = KIND_START;
                out_res_next   = 1'b1;
                out_last_next  = 1'b0;
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        out_x_next   = '0;
                        out_y_next   = '0;
                        out_res_next = 1'b0;
                    end
                    PH_START:
                    begin
                        phase_next = (remaining_reg == '0) ? PH_END : PH_INTERIOR;
                    end
                    PH_INTERIOR:
                    begin
                        out_kind_next  = KIND_INTERIOR;
                        decision_next  = decision_reg + (minor_step ? inc_diag_reg : inc_axial_reg);
                        cur_x_next     = move_x ? cur_x_reg + step_x : cur_x_reg;
                        cur_y_next     = move_y ? cur_y_reg + step_y : cur_y_reg;
                        remaining_next = remaining_reg - SpanBits'(1);
                        if (remaining_reg == SpanBits'(1))
                        begin
                            phase_next = PH_END;
                        end
                    end
                    PH_END:
                    begin
                        out_x_next    = end_x_reg;
                        out_y_next    = end_y_reg;
                        out_kind_next = KIND_END;
                        out_last_next = 1'b1;
                        phase_next    = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            end_x_reg     <= '0;
            end_y_reg     <= '0;
            remaining_reg <= '0;
            inc_axial_reg <= '0;
            inc_diag_reg  <= '0;
            decision_reg  <= '0;
            dir_x_neg_reg <= 1'b0;
            dir_y_neg_reg <= 1'b0;
            y_major_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_kind_reg  <= KIND_START;
            out_res_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            end_x_reg     <= end_x_next;
            end_y_reg     <= end_y_next;
            remaining_reg <= remaining_next;
            inc_axial_reg <= inc_axial_next;
            inc_diag_reg  <= inc_diag_next;
            decision_reg  <= decision_next;
            dir_x_neg_reg <= dir_x_neg_next;
            dir_y_neg_reg <= dir_y_neg_next;
            y_major_reg   <= y_major_next;
            out_valid_reg <= out_valid_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_kind_reg  <= out_kind_next;
            out_res_reg   <= out_res_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign pixel.valid      = out_valid_reg;
    assign pixel.pixel_x    = out_x_reg;
    assign pixel.pixel_y    = out_y_reg;
    assign pixel.pixel_kind = out_kind_reg;
    assign pixel.valid_res  = out_res_reg;
    assign pixel.last       = out_last_reg;

endmodule
